// ===== rtl/core/ili_pkg.sv =====
// shared types and constants for the indexed list store
package ili_pkg;

  localparam int DATA_W = 32;
  localparam int ACT_W  = 3;
  localparam int POS_W  = 8;
  localparam int LEN_W  = 7;
  localparam int ST_W   = 2;

  // request actions
  localparam logic [ACT_W-1:0] ACT_READ     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_HEAD = 3'd1;
  localparam logic [ACT_W-1:0] ACT_APPEND   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_INS_POS  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DELETE   = 3'd4;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_NOP,
    CELL_READ,
    CELL_INS,
    CELL_DEL
  } cell_op_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e           op;
    logic [LEN_W-1:0]   pos;
    logic [DATA_W-1:0]  value;
  } cell_cmd_t;

endpackage

// ===== rtl/core/indexed_list_insert_delete.sv =====
// top level of the indexed list store built from a shifting cell chain
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  in      | to block  | in_valid_i / in_ready_o    | action_i, position_i, value_i
//  out     | from block| out_valid_o / out_ready_i  | read_value_o, status_o, length_o
//
// after its transfer each request is registered in turn through the chain update and cell read, the
// group or, and the final or into the output register, which waits while a result there is untaken;
// the next transfer in is taken only once the block is back in idle, so a new request is not taken
// before the last one's result is in the output register
// the chain moves every cell at or after the position at once in the update; the or-tree over
// the cells sets the remaining latency
// reset clears the length and control; cell contents stay undefined until
// written and need no clearing pass
// a waiting result does not block the next transfer in; only a second result
// completing while the first is still untaken holds the block

module indexed_list_insert_delete import ili_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ACT_W-1:0]         action_i,
  input  logic signed [POS_W-1:0]  position_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [ST_W-1:0]          status_o,
  output logic [LEN_W-1:0]         length_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_GATHER = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  localparam logic [LEN_W-1:0] CapLen = LEN_W'(CAPACITY);

  logic [1:0]        state_q, state_d;
  logic [LEN_W-1:0]  count_q, count_d;

  // captured request
  logic [ACT_W-1:0]  act_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] value_q;

  // pending status between the chain update and the result
  logic [ST_W-1:0]   status_q, status_d;

  // output register
  logic              out_valid_q;
  logic [DATA_W-1:0] rdv_q;
  logic [ST_W-1:0]   ost_q;
  logic [LEN_W-1:0]  olen_q;

  cell_cmd_t         cmd;
  logic              accept;
  logic              neg;
  logic [LEN_W:0]    pos_ext;
  logic              full;
  logic              load_out;
  logic [DATA_W-1:0] gathered;

  assign accept   = in_valid_i && in_ready_o;
  assign neg      = pos_q[POS_W-1];
  assign pos_ext  = {1'b0, pos_q[LEN_W-1:0]};
  assign full     = (count_q >= CapLen);
  assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // decode the request against the current length in the update cycle
  always_comb begin
    cmd.op    = CELL_NOP;
    cmd.pos   = pos_q[LEN_W-1:0];
    cmd.value = value_q;
    status_d  = status_q;
    count_d   = count_q;
    if (state_q == S_EXEC) begin
      status_d = ST_OK;
      case (act_q)
        ACT_READ: begin
          if (neg || pos_ext >= {1'b0, count_q}) status_d = ST_RANGE;
          else cmd.op = CELL_READ;
        end
        ACT_INS_HEAD: begin
          cmd.pos = '0;
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.op  = CELL_INS;
            count_d = count_q + 1'b1;
          end
        end
        ACT_APPEND: begin
          cmd.pos = count_q;
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.op  = CELL_INS;
            count_d = count_q + 1'b1;
          end
        end
        ACT_INS_POS: begin
          if (neg || pos_ext > {1'b0, count_q}) begin
            status_d = ST_RANGE;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.op  = CELL_INS;
            count_d = count_q + 1'b1;
          end
        end
        ACT_DELETE: begin
          if (neg || pos_ext >= {1'b0, count_q}) begin
            status_d = ST_RANGE;
          end else begin
            cmd.op  = CELL_DEL;
            count_d = count_q - 1'b1;
          end
        end
        default: begin
          status_d = ST_RANGE;
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept) state_d = S_EXEC;
      S_EXEC:   state_d = S_GATHER;
      S_GATHER: state_d = S_DONE;
      S_DONE:   if (load_out) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= action_i;
      pos_q   <= position_i;
      value_q <= value_i;
    end
    status_q <= status_d;
    if (load_out) begin
      rdv_q  <= gathered;
      ost_q  <= status_q;
      olen_q <= count_q;
    end
  end

  // cell chain: inserts pull from the left neighbor, deletes from the right
  logic [DATA_W-1:0]               cell_val [CAPACITY];
  logic [DATA_W-1:0]               left_w   [CAPACITY];
  logic [DATA_W-1:0]               right_w  [CAPACITY];
  logic [CAPACITY-1:0][DATA_W-1:0] cell_rd;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = '0;
    end else begin : g_mid_l
      assign left_w[i] = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w[i] = '0;
    end else begin : g_mid_r
      assign right_w[i] = cell_val[i+1];
    end

    ili_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left_w[i]),
      .right_i (right_w[i]),
      .val_o   (cell_val[i]),
      .rd_o    (cell_rd[i])
    );
  end

  // only the addressed cell drives a nonzero read value; the group stage
  // loads in the gather state and holds while the result waits for the output register
  ili_gather #(
    .CAPACITY (CAPACITY)
  ) u_gather (
    .clk_i  (clk_i),
    .en_i   (state_q == S_GATHER),
    .leaf_i (cell_rd),
    .sum_o  (gathered)
  );

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign read_value_o = rdv_q;
  assign status_o     = ost_q;
  assign length_o     = olen_q;

endmodule

// ===== rtl/core/ili_cell.sv =====
// one storage cell of the shifting element chain
module ili_cell import ili_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk_i,
  input  cell_cmd_t         cmd_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] val_o,
  output logic [DATA_W-1:0] rd_o
);

  localparam logic [LEN_W-1:0] MyIdx = LEN_W'(IDX);

  logic [DATA_W-1:0] val_q, val_d;
  logic [DATA_W-1:0] rd_q, rd_d;
  logic              hit, after;

  assign hit   = (cmd_i.pos == MyIdx);
  assign after = (MyIdx > cmd_i.pos);

  always_comb begin
    val_d = val_q;
    rd_d  = '0;
    case (cmd_i.op)
      CELL_READ: begin
        if (hit) rd_d = val_q;
      end
      CELL_INS: begin
        if (hit) val_d = cmd_i.value;
        else if (after) val_d = left_i;
      end
      CELL_DEL: begin
        if (hit || after) val_d = right_i;
      end
      default: begin
        val_d = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rd_q  <= rd_d;
  end

  assign val_o = val_q;
  assign rd_o  = rd_q;

endmodule

// ===== rtl/core/ili_gather.sv =====
// registered or-tree that collects the one selected cell value
module ili_gather import ili_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [CAPACITY-1:0][DATA_W-1:0]  leaf_i,
  output logic [DATA_W-1:0]                sum_o
);

  localparam int GrpSize = 8;
  localparam int NumGrp  = (CAPACITY + GrpSize - 1) / GrpSize;

  logic [NumGrp-1:0][DATA_W-1:0] grp_d, grp_q;

  always_comb begin
    grp_d = '0;
    for (int g = 0; g < NumGrp; g++) begin
      for (int k = 0; k < GrpSize; k++) begin
        if (g * GrpSize + k < CAPACITY) begin
          grp_d[g] = grp_d[g] | leaf_i[g * GrpSize + k];
        end
      end
    end
  end

  // group results hold while the final result waits for the output register
  always_ff @(posedge clk_i) begin
    if (en_i) grp_q <= grp_d;
  end

  always_comb begin
    sum_o = '0;
    for (int g = 0; g < NumGrp; g++) begin
      sum_o = sum_o | grp_q[g];
    end
  end

endmodule

// ===== verif/tb_indexed_list_insert_delete.sv =====
// testbench for the indexed list store: directed and random requests checked against a predictor
module tb_indexed_list_insert_delete import ili_pkg::*;;

  localparam int CAPACITY     = 64;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;   // long output stall for the pressure test
  localparam int DRAIN_CYCLES = 20;    // idle time after the last result is taken
  localparam int MAX_REPORTS  = 10;

  // action codes the block must reject
  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [POS_W-1:0]  POS_MAX = 8'sh7f;
  localparam logic signed [POS_W-1:0]  POS_MIN = 8'sh80;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [ST_W-1:0]          status;
    logic [LEN_W-1:0]         length;
  } list_result_t;

  // request mix used by the random traffic
  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} traffic_mix_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [ACT_W-1:0]         action_i;
  logic signed [POS_W-1:0]  position_i;
  logic signed [DATA_W-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] read_value_o;
  logic [ST_W-1:0]          status_o;
  logic [LEN_W-1:0]         length_o;

  // predicted contents of the list and the results still owed by the block
  logic signed [DATA_W-1:0] list_mem [CAPACITY];
  int                       list_len;
  list_result_t             pending_results[$];
  list_result_t             oldest_result;

  int error_count;
  int cycle_count;
  int burst_left;
  bit steady_input;   // sender offers back to back, no gaps
  bit hold_output;    // asks the receiver for one long stall

  indexed_list_insert_delete #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_value_o(read_value_o),
    .status_o    (status_o),
    .length_o    (length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // open a slot at index at, shifting the tail up by one
  function automatic void shift_in(int at, logic signed [DATA_W-1:0] val);
    for (int i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
    list_mem[at] = val;
    list_len++;
  endfunction

  // predicted result of one request, updating the list as the block should
  function automatic list_result_t apply_request(logic [ACT_W-1:0] act,
                                                 logic signed [POS_W-1:0] pos,
                                                 logic signed [DATA_W-1:0] val);
    list_result_t r;
    int p;
    bit is_full;
    r.read_value = '0;
    r.status     = ST_OK;
    p            = pos;   // sign extends
    is_full      = (list_len >= CAPACITY);
    case (act)
      ACT_READ: begin
        if (p < 0 || p >= list_len) r.status = ST_RANGE;
        else r.read_value = list_mem[p];
      end
      ACT_INS_HEAD: begin
        if (is_full) r.status = ST_FULL;
        else shift_in(0, val);
      end
      ACT_APPEND: begin
        if (is_full) r.status = ST_FULL;
        else shift_in(list_len, val);
      end
      ACT_INS_POS: begin
        // a bad position wins over a full store
        if (p < 0 || p > list_len) r.status = ST_RANGE;
        else if (is_full) r.status = ST_FULL;
        else shift_in(p, val);
      end
      ACT_DELETE: begin
        if (p < 0 || p >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      default: r.status = ST_RANGE;
    endcase
    r.length = LEN_W'(list_len);
    return r;
  endfunction

  task automatic note_mismatch(string what, longint expected_v, longint actual_v);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s expected %0d got %0d",
               cycle_count, what, expected_v, actual_v);
  endtask

  // one request: random gap per burst, then hold valid until the transfer
  task automatic send_request(input logic [ACT_W-1:0] act,
                              input logic signed [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] val);
    int gap;
    gap = 0;
    if (!steady_input) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
      end
      burst_left--;
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    action_i   = act;
    position_i = pos;
    value_i    = val;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(apply_request(act, pos, val));
  endtask

  // random request, mostly well formed positions against the current length
  task automatic send_random_request(input traffic_mix_e mix);
    logic [ACT_W-1:0]         act;
    logic signed [POS_W-1:0]  pos;
    logic signed [DATA_W-1:0] val;
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (roll < 25) act = ACT_INS_HEAD;
        else if (roll < 50) act = ACT_APPEND;
        else if (roll < 75) act = ACT_INS_POS;
        else if (roll < 87) act = ACT_READ;
        else if (roll < 96) act = ACT_DELETE;
        else act = ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      end
      MIX_SHRINK: begin
        if (roll < 5) act = ACT_INS_HEAD;
        else if (roll < 10) act = ACT_APPEND;
        else if (roll < 15) act = ACT_INS_POS;
        else if (roll < 32) act = ACT_READ;
        else if (roll < 96) act = ACT_DELETE;
        else act = ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      end
      default: begin
        if (roll < 15) act = ACT_INS_HEAD;
        else if (roll < 30) act = ACT_APPEND;
        else if (roll < 50) act = ACT_INS_POS;
        else if (roll < 72) act = ACT_READ;
        else if (roll < 94) act = ACT_DELETE;
        else act = ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      end
    endcase
    case ($urandom_range(0, 11))
      0:       pos = POS_W'($urandom_range(128, 255));            // negative
      1:       pos = POS_W'($urandom_range(0, 255));
      2:       pos = POS_W'(list_len);                            // one past the end
      3:       pos = POS_W'(list_len + $urandom_range(1, 8));     // beyond the end
      default: pos = POS_W'($urandom_range(0, list_len));
    endcase
    case ($urandom_range(0, 15))
      0:       val = VAL_MAX;
      1:       val = VAL_MIN;
      2:       val = '0;
      3:       val = '1;
      default: val = DATA_W'($urandom);
    endcase
    send_request(act, pos, val);
  endtask

  // empty store: reads, deletes and inserts past the end all miss; unused codes
  task automatic test_empty_store();
    send_request(ACT_READ, 8'sd0, VAL_MAX);
    send_request(ACT_DELETE, 8'sd0, '0);
    send_request(ACT_INS_POS, 8'sd1, 32'sd7);
    for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++)
      send_request(ACT_W'(a), 8'sd0, VAL_MIN);
  endtask

  // every insert kind, bad positions at both extremes, reads and deletes
  task automatic test_insert_positions();
    send_request(ACT_INS_HEAD, POS_MIN, VAL_MAX);
    send_request(ACT_APPEND, POS_MAX, VAL_MIN);
    send_request(ACT_INS_POS, 8'sd2, -32'sd1);          // at the length: appends
    send_request(ACT_INS_POS, 8'sd0, '0);
    send_request(ACT_INS_POS, 8'sd2, 32'sh5a5a_a5a5);
    send_request(ACT_INS_POS, 8'sd6, 32'sd1);           // past the length
    send_request(ACT_INS_POS, POS_MIN, 32'sd2);
    send_request(ACT_INS_POS, POS_MAX, 32'sd3);
    for (int i = 0; i <= 5; i++) send_request(ACT_READ, POS_W'(i), VAL_MAX);
    send_request(ACT_READ, POS_MAX, '0);
    send_request(ACT_READ, POS_MIN, '0);
    send_request(ACT_DELETE, 8'sd4, '0);                // last entry
    send_request(ACT_DELETE, 8'sd0, '0);
    send_request(ACT_DELETE, -8'sd1, '0);
    send_request(ACT_DELETE, POS_MAX, '0);
  endtask

  // fill to capacity and beyond, churn, shrink and refill partly
  task automatic test_random_traffic();
    repeat (120) send_random_request(MIX_GROW);
    repeat (100) send_random_request(MIX_EVEN);
    repeat (110) send_random_request(MIX_SHRINK);
    repeat (20) send_random_request(MIX_EVEN);
  endtask

  // receiver stalls for a long stretch while requests keep coming
  task automatic test_stalled_output();
    steady_input = 1'b1;
    hold_output  = 1'b1;
    repeat (40) send_random_request(MIX_GROW);
    steady_input = 1'b0;
  endtask

  // receiver: ready pattern changes mode every so often, plus the long hold
  initial begin
    int mode;
    int mode_left;
    int phase;
    mode        = 0;
    mode_left   = 0;
    phase       = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_output) begin
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_output = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(32, 160);
        end
        mode_left--;
        phase++;
        case (mode)
          0:       out_ready_i = 1'b1;
          1:       out_ready_i = ($urandom_range(0, 3) != 0);
          2:       out_ready_i = ($urandom_range(0, 3) == 0);
          default: out_ready_i = (phase % 3 == 0);
        endcase
      end
    end
  end

  // result check against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result, status", -1, status_o);
      end else begin
        oldest_result = pending_results.pop_front();
        if (read_value_o !== oldest_result.read_value)
          note_mismatch("read_value", oldest_result.read_value, read_value_o);
        if (status_o !== oldest_result.status)
          note_mismatch("status", oldest_result.status, status_o);
        if (length_o !== oldest_result.length)
          note_mismatch("length", oldest_result.length, length_o);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    action_i     = ACT_READ;
    position_i   = '0;
    value_i      = '0;
    list_len     = 0;
    error_count  = 0;
    cycle_count  = 0;
    burst_left   = 0;
    steady_input = 1'b0;
    hold_output  = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_store();
    test_insert_positions();
    test_random_traffic();
    test_stalled_output();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ili_pkg.sv
rtl/core/ili_cell.sv
rtl/core/ili_gather.sv
rtl/core/indexed_list_insert_delete.sv
verif/tb_indexed_list_insert_delete.sv
